[src/ssr_pkg.sv]
// Shared types, constants and helpers for the SRRIP stream replacement engine.
package ssr_pkg;

	localparam int unsigned ADDR_W    = 64;
	localparam int unsigned STRIDE_W  = 8;
	localparam int unsigned RUN_W     = 4;
	localparam int unsigned DET_W     = ADDR_W + STRIDE_W + RUN_W + 1;
	localparam int unsigned RRPV_W    = 2;
	localparam int unsigned CTR_W     = 2;
	localparam int unsigned MASK_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 4;
	localparam int unsigned IN_DATA_W = 112;
	localparam int unsigned OUT_DATA_W = 8;

	localparam logic [RRPV_W-1:0] RRPV_MAX = 2'd3;
	localparam logic [CTR_W-1:0]  CTR_MAX  = 2'd3;
	localparam logic [CTR_W-1:0]  CTR_INIT = 2'd1;
	localparam logic [RUN_W-1:0]  RUN_MAX  = 4'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STREAM_THR = 2'd0,
		CFG_REUSE_THR  = 2'd1,
		CFG_NEAR_RRPV  = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		REQ_VICTIM = 1'b0,
		REQ_UPDATE = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t            req_type;
		logic [MASK_W-1:0]    valid_mask;
		logic [7:0]           pc_low;
		logic [ADDR_W-1:0]    line_address;
		logic                 hit_flag;
		logic [3:0]           random_nibble;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   last_address;
		logic [STRIDE_W-1:0] last_stride;
		logic [RUN_W-1:0]    stride_run;
		logic                streaming;
	} det_t;

	// value modulo a constant: a mask for a power of two, else shifted compare and subtract
	function automatic logic [15:0] mod_const(input logic [15:0] v, input int unsigned m);
		logic [31:0] r;
		logic [31:0] mm;
		r  = 32'(v);
		mm = 32'(m);
		if ((mm & (mm - 32'd1)) == 32'd0) begin
			r = r & (mm - 32'd1);
		end else begin
			for (int k = 15; k >= 0; k--) begin
				if (r >= (mm << k)) begin
					r = r - (mm << k);
				end
			end
		end
		return r[15:0];
	endfunction

endpackage

[src/ssr_ram.sv]
// Generic simple dual-port RAM with registered read.
module ssr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/ship_srrip_stream_replacement.sv]
// Top level: SRRIP replacement engine with signature predictor and stride stream detector.
// A word accepted at an edge is computed from the memory read in the next cycle and lands
//   in the output register once that register is free; m_tvalid rises then.
// No new word is taken until the last leaves stage 1 and writes back the per-set memories.
// Reset: control and configuration clear at once; then a clearing pass over every
//   address fills all memories while s_tready stays low; configuration writes are
//   taken throughout.
module ship_srrip_stream_replacement #(
	parameter int NUM_SETS = 2048,
	parameter int NUM_WAYS = 16,
	parameter int SIG_BITS = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// set_index[10:0], way_index[14:11], valid_mask[30:15], pc_low[38:31],
	// line_address[102:39], hit_flag[103], random_nibble[107:104], zero pad
	input  logic [ssr_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// victim_way[3:0], set_streaming[4], inserted_rrpv[6:5], zero pad
	output logic [ssr_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ssr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssr_pkg::CFG_DAT_W-1:0]     cfg_data
);

	import ssr_pkg::*;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = $clog2(NUM_WAYS);
	localparam int ROW_W = NUM_WAYS * RRPV_W;
	localparam int SIG_N = 1 << SIG_BITS;
	localparam int CLR_N = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
	localparam int CLR_W = $clog2(CLR_N);

	// configuration
	logic [3:0]        stream_thr_q;
	logic [1:0]        reuse_thr_q;
	logic [RRPV_W-1:0] near_rrpv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_thr_q <= 4'd6;
			reuse_thr_q  <= 2'd2;
			near_rrpv_q  <= 2'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STREAM_THR: stream_thr_q <= cfg_data;
				CFG_REUSE_THR:  reuse_thr_q  <= cfg_data[1:0];
				CFG_NEAR_RRPV:  near_rrpv_q  <= cfg_data[RRPV_W-1:0];
				default: ;
			endcase
		end
	end

	// clearing pass
	logic             clearing_q;
	logic [CLR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == CLR_W'(CLR_N - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// input decode
	req_t              in_req;
	logic [SET_W-1:0]  in_set;
	logic [WAY_W-1:0]  in_way;
	logic [SIG_BITS-1:0] in_sig;
	logic [15:0]       set_mod;
	logic [15:0]       way_mod;
	logic [11:0]       pc_mix;

	always_comb begin
		in_req.req_type      = req_kind_t'(s_tuser);
		in_req.valid_mask    = s_tdata[30:15];
		in_req.pc_low        = s_tdata[38:31];
		in_req.line_address  = s_tdata[102:39];
		in_req.hit_flag      = s_tdata[103];
		in_req.random_nibble = s_tdata[107:104];
		set_mod = mod_const({5'd0, s_tdata[10:0]}, NUM_SETS);
		way_mod = mod_const({12'd0, s_tdata[14:11]}, NUM_WAYS);
		in_set  = set_mod[SET_W-1:0];
		in_way  = way_mod[WAY_W-1:0];
		pc_mix  = 12'({s_tdata[38:31] ^ {2'b00, s_tdata[38:33]}});
		in_sig  = pc_mix[SIG_BITS-1:0];
	end

	// stage 1: memory read in flight / data returned
	logic                valid_s1;
	req_t                req_s1;
	logic [SET_W-1:0]    set_s1;
	logic [WAY_W-1:0]    way_s1;
	logic [SIG_BITS-1:0] sig_s1;
	logic                accept;
	logic                out_free;
	logic                s1_done;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign s_tready = !valid_s1 && !clearing_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s1_done  = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_req;
			set_s1 <= in_set;
			way_s1 <= in_way;
			sig_s1 <= in_sig;
		end
	end

	// memories; a stalled item keeps re-reading its own address
	logic [SET_W-1:0]    rd_set;
	logic [SIG_BITS-1:0] rd_sig;
	logic [ROW_W-1:0]    row_rd;
	logic [DET_W-1:0]    det_rd;
	logic [CTR_W-1:0]    ctr_rd;
	logic                rrpv_we;
	logic [SET_W-1:0]    rrpv_waddr;
	logic [ROW_W-1:0]    rrpv_wdata;
	logic                det_we;
	logic [SET_W-1:0]    det_waddr;
	logic [DET_W-1:0]    det_wdata;
	logic                sig_we;
	logic [SIG_BITS-1:0] sig_waddr;
	logic [CTR_W-1:0]    sig_wdata;

	assign rd_set = accept ? in_set : set_s1;
	assign rd_sig = accept ? in_sig : sig_s1;

	ssr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrpv_ram (
		.clk   (clk),
		.we    (rrpv_we),
		.waddr (rrpv_waddr),
		.wdata (rrpv_wdata),
		.raddr (rd_set),
		.rdata (row_rd)
	);

	ssr_ram #(.WIDTH(DET_W), .DEPTH(NUM_SETS)) u_det_ram (
		.clk   (clk),
		.we    (det_we),
		.waddr (det_waddr),
		.wdata (det_wdata),
		.raddr (rd_set),
		.rdata (det_rd)
	);

	ssr_ram #(.WIDTH(CTR_W), .DEPTH(SIG_N)) u_sig_ram (
		.clk   (clk),
		.we    (sig_we),
		.waddr (sig_waddr),
		.wdata (sig_wdata),
		.raddr (rd_sig),
		.rdata (ctr_rd)
	);

	// stage 1 datapath
	det_t              det;
	det_t              det_new;
	logic [31:0]       mask_ext;
	logic              any_inv;
	logic [WAY_W-1:0]  first_inv;
	logic              any_hi;
	logic              any_lo;
	logic              any_both;
	logic [RRPV_W-1:0] top;
	logic [WAY_W-1:0]  first_top;
	logic [WAY_W-1:0]  victim;
	logic [ROW_W-1:0]  aged_row;
	logic [ROW_W-1:0]  upd_row;
	logic [ROW_W-1:0]  new_row;
	logic [ADDR_W-1:0] delta;
	logic [ADDR_W-1:0] stride_ext;
	logic              run_hit;
	logic [CTR_W-1:0]  ctr_new;
	logic [RRPV_W-1:0] ins;
	logic              streaming_out;
	logic [OUT_DATA_W-1:0] out_data;

	always_comb begin
		det      = det_t'(det_rd);
		mask_ext = {16'hFFFF, req_s1.valid_mask};
		any_inv  = 1'b0;
		first_inv = '0;
		any_hi   = 1'b0;
		any_lo   = 1'b0;
		any_both = 1'b0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (!mask_ext[w]) begin
				any_inv   = 1'b1;
				first_inv = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			any_hi   = any_hi | row_rd[2*w+1];
			any_lo   = any_lo | row_rd[2*w];
			any_both = any_both | (row_rd[2*w+1] & row_rd[2*w]);
		end
		top = any_hi ? (any_both ? 2'd3 : 2'd2) : (any_lo ? 2'd1 : 2'd0);
		first_top = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row_rd[2*w +: RRPV_W] == top) begin
				first_top = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged_row[2*w +: RRPV_W] = row_rd[2*w +: RRPV_W] + ~top;
		end
		victim = any_inv ? first_inv : first_top;

		// stride detector
		delta      = req_s1.line_address - det.last_address;
		stride_ext = {{(ADDR_W-STRIDE_W){det.last_stride[STRIDE_W-1]}}, det.last_stride};
		run_hit    = (det.last_address != '0) && (delta == stride_ext) && (delta != '0);
		det_new.last_address = req_s1.line_address;
		det_new.last_stride  = delta[STRIDE_W-1:0];
		if (run_hit) begin
			det_new.stride_run = (det.stride_run == RUN_MAX) ? RUN_MAX : det.stride_run + 1'b1;
		end else begin
			det_new.stride_run = '0;
		end
		det_new.streaming = (det_new.stride_run >= stream_thr_q);

		// insertion and signature counter
		ctr_new = ctr_rd;
		if (req_s1.hit_flag) begin
			ins = '0;
			if (ctr_rd != CTR_MAX) begin
				ctr_new = ctr_rd + 1'b1;
			end
		end else if (det_new.streaming) begin
			ins = RRPV_MAX;
			if ((req_s1.random_nibble != 4'd0) && (ctr_rd != '0)) begin
				ctr_new = ctr_rd - 1'b1;
			end
		end else begin
			ins = (ctr_rd >= reuse_thr_q) ? near_rrpv_q : RRPV_MAX;
			if (ctr_rd != '0) begin
				ctr_new = ctr_rd - 1'b1;
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			upd_row[2*w +: RRPV_W] = (way_s1 == WAY_W'(w)) ? ins : row_rd[2*w +: RRPV_W];
		end

		if (req_s1.req_type == REQ_UPDATE) begin
			new_row       = upd_row;
			streaming_out = det_new.streaming;
			out_data      = {1'b0, ins, streaming_out, 4'd0};
		end else begin
			new_row       = any_inv ? row_rd : aged_row;
			streaming_out = det.streaming;
			out_data      = {3'd0, streaming_out, 4'(victim)};
		end
	end

	// write ports: clearing pass or stage 1 write-back
	always_comb begin
		if (clearing_q) begin
			rrpv_we    = ({1'b0, clr_q} < (CLR_W+1)'(NUM_SETS));
			rrpv_waddr = clr_q[SET_W-1:0];
			rrpv_wdata = '1;
			det_we     = rrpv_we;
			det_waddr  = clr_q[SET_W-1:0];
			det_wdata  = '0;
			sig_we     = ({1'b0, clr_q} < (CLR_W+1)'(SIG_N));
			sig_waddr  = clr_q[SIG_BITS-1:0];
			sig_wdata  = CTR_INIT;
		end else begin
			rrpv_we    = s1_done;
			rrpv_waddr = set_s1;
			rrpv_wdata = new_row;
			det_we     = s1_done && (req_s1.req_type == REQ_UPDATE);
			det_waddr  = set_s1;
			det_wdata  = DET_W'(det_new);
			sig_we     = det_we;
			sig_waddr  = sig_s1;
			sig_wdata  = ctr_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			out_data_q <= out_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// checks
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !s_tready)
		else $error("item in flight during clearing pass");

	a_done_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done |-> (!out_valid_q || m_tready))
		else $error("write-back while output register is held");

	a_done_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done |=> m_tvalid)
		else $error("completed item produced no output word");

	a_accept_reads_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && !s_tready)
		else $error("accepted item not held in stage 1");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !accept)
		else $error("second item accepted over an open read-modify-write");

endmodule

[tb/ship_srrip_stream_replacement_checker.sv]
// Checker: follows request, result and register channels, tracks state and compares results.
`timescale 1ns / 100ps

module ship_srrip_stream_replacement_checker #(
	parameter int NUM_SETS = 2048,
	parameter int NUM_WAYS = 16,
	parameter int SIG_BITS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ssr_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [ssr_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssr_pkg::CFG_DAT_W-1:0]  cfg_data,
	output int unsigned                    mismatches,
	output int unsigned                    pending
);

	import ssr_pkg::*;

	localparam int SIG_N = 1 << SIG_BITS;
	localparam logic [3:0] STREAM_THR_RST = 4'd6;
	localparam logic [1:0] REUSE_THR_RST  = 2'd2;
	localparam logic [1:0] NEAR_RRPV_RST  = 2'd1;

	typedef struct packed {
		logic [RRPV_W-1:0] rrpv;
		logic              streaming;
		logic [3:0]        way;
	} outcome_t;

	logic [RRPV_W-1:0]   rrpv_q     [NUM_SETS*NUM_WAYS];
	logic [CTR_W-1:0]    sig_ctr    [SIG_N];
	logic [ADDR_W-1:0]   prev_addr  [NUM_SETS];
	logic [STRIDE_W-1:0] prev_stride[NUM_SETS];
	logic [RUN_W-1:0]    run_len    [NUM_SETS];
	logic                stream_set [NUM_SETS];
	logic [3:0]          stream_thr;
	logic [1:0]          reuse_thr;
	logic [1:0]          near_rrpv;
	outcome_t            pending_outcomes[$];

	task automatic report(input string msg);
		$display("%0t ns checker: %s", $time, msg);
		mismatches++;
	endtask

	// one request against the tracked state; returns the result word it must produce
	task automatic replace_step(input logic kind, input logic [IN_DATA_W-1:0] d,
			output outcome_t o);
		int s, w, base, k;
		logic [7:0] pcv, sig_full;
		logic [ADDR_W-1:0] addr, delta, stride_ext;
		logic [1:0] peak, ins;
		logic [CTR_W-1:0] ctr;
		bit found;
		s        = int'(d[10:0]) % NUM_SETS;
		w        = int'(d[14:11]) % NUM_WAYS;
		pcv      = d[38:31];
		addr     = d[102:39];
		sig_full = pcv ^ (pcv >> 2);
		base     = s * NUM_WAYS;
		o        = '0;
		if (kind == REQ_VICTIM) begin
			found = 0;
			for (k = 0; k < NUM_WAYS; k++) begin
				if (!found && k < MASK_W && !d[15+k]) begin
					o.way = 4'(k);
					found = 1;
				end
			end
			if (!found) begin
				peak = '0;
				for (k = 0; k < NUM_WAYS; k++)
					if (rrpv_q[base+k] > peak)
						peak = rrpv_q[base+k];
				for (k = 0; k < NUM_WAYS; k++)
					rrpv_q[base+k] = rrpv_q[base+k] + (RRPV_MAX - peak);
				for (k = 0; k < NUM_WAYS; k++) begin
					if (!found && rrpv_q[base+k] == RRPV_MAX) begin
						o.way = 4'(k);
						found = 1;
					end
				end
			end
			o.streaming = stream_set[s];
		end else begin
			delta      = addr - prev_addr[s];
			stride_ext = {{(ADDR_W-STRIDE_W){prev_stride[s][STRIDE_W-1]}}, prev_stride[s]};
			if (prev_addr[s] != '0 && delta == stride_ext && delta != '0) begin
				if (run_len[s] != RUN_MAX)
					run_len[s] = run_len[s] + 1'b1;
			end else begin
				run_len[s] = '0;
			end
			prev_stride[s] = delta[STRIDE_W-1:0];
			prev_addr[s]   = addr;
			stream_set[s]  = (run_len[s] >= stream_thr);

			ctr = sig_ctr[int'(sig_full) % SIG_N];
			if (d[103]) begin
				if (ctr != CTR_MAX)
					ctr = ctr + 1'b1;
				ins = '0;
			end else if (stream_set[s]) begin
				// streaming miss: zero nibble bypasses the decay
				ins = RRPV_MAX;
				if (d[107:104] != 4'd0 && ctr != '0)
					ctr = ctr - 1'b1;
			end else begin
				ins = (ctr >= reuse_thr) ? near_rrpv : RRPV_MAX;
				if (ctr != '0)
					ctr = ctr - 1'b1;
			end
			sig_ctr[int'(sig_full) % SIG_N] = ctr;
			rrpv_q[base+w] = ins;
			o.streaming = stream_set[s];
			o.rrpv      = ins;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SETS*NUM_WAYS; i++)
				rrpv_q[i] = RRPV_MAX;
			for (int i = 0; i < SIG_N; i++)
				sig_ctr[i] = CTR_INIT;
			for (int i = 0; i < NUM_SETS; i++) begin
				prev_addr[i]   = '0;
				prev_stride[i] = '0;
				run_len[i]     = '0;
				stream_set[i]  = 1'b0;
			end
			stream_thr = STREAM_THR_RST;
			reuse_thr  = REUSE_THR_RST;
			near_rrpv  = NEAR_RRPV_RST;
			pending_outcomes.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STREAM_THR: stream_thr = cfg_data[3:0];
					CFG_REUSE_THR:  reuse_thr  = cfg_data[1:0];
					CFG_NEAR_RRPV:  near_rrpv  = cfg_data[1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[6:0];
				if (pending_outcomes.size() == 0) begin
					report($sformatf("result word 0x%02h with no request outstanding", m_tdata));
				end else begin
					want = pending_outcomes.pop_front();
					if (got.way !== want.way)
						report($sformatf("victim_way: want %0d, got %0d", want.way, got.way));
					if (got.streaming !== want.streaming)
						report($sformatf("set_streaming: want %0d, got %0d",
							want.streaming, got.streaming));
					if (got.rrpv !== want.rrpv)
						report($sformatf("inserted_rrpv: want %0d, got %0d", want.rrpv, got.rrpv));
				end
			end
			if (s_tvalid && s_tready) begin
				replace_step(s_tuser, s_tdata, want);
				pending_outcomes.push_back(want);
			end
			pending = pending_outcomes.size();
		end
	end

endmodule

[tb/ship_srrip_stream_replacement_tb.sv]
// Testbench top: clock, reset, register writes, request stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module ship_srrip_stream_replacement_tb;
	import ssr_pkg::*;

	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_data;
	int unsigned           err_total;
	int unsigned           pending;

	bit                    calm;
	bit                    hold_req;
	logic [10:0]           hot_sets[12];

	ship_srrip_stream_replacement DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	ship_srrip_stream_replacement_checker CHK (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(err_total),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_item(input req_kind_t kind, input logic [10:0] set_i,
			input logic [3:0] way_i, input logic [15:0] mask_i, input logic [7:0] pc_i,
			input logic [63:0] addr_i, input logic hit_i, input logic [3:0] nib_i);
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = {4'd0, nib_i, hit_i, addr_i, pc_i, mask_i, way_i, set_i};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drain every outstanding result, then let the pipeline go quiet
	task automatic settle();
		s_tvalid = 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_regs(input logic [3:0] st, input logic [1:0] rt, input logic [1:0] nr);
		write_reg(CFG_STREAM_THR, st);
		write_reg(CFG_REUSE_THR, 4'(rt));
		write_reg(CFG_NEAR_RRPV, 4'(nr));
	endtask

	function automatic logic [15:0] pick_mask();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 65)
			return 16'hFFFF;
		if (r < 85)
			return ~(16'h0001 << $urandom_range(15));
		return 16'($urandom);
	endfunction

	function automatic logic [3:0] pick_nibble();
		return ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom);
	endfunction

	task automatic run_random(input int unsigned count);
		int unsigned sent, len, k, r;
		logic [10:0] set_i;
		logic [63:0] addr, step;
		logic [7:0]  pc_base, lane;
		sent = 0;
		while (sent < count) begin
			r       = $urandom_range(99);
			set_i   = hot_sets[$urandom_range(11)];
			pc_base = 8'($urandom);
			if (r < 60) begin
				// strided access run on one set, with victim lookups and broken strides mixed in
				addr = ($urandom_range(9) == 0) ? 64'd0 : {$urandom, $urandom};
				k    = $urandom_range(19);
				lane = 8'($urandom_range(1, 255));
				if (k == 0)
					step = '0;
				else if (k < 3)
					step = {$urandom, $urandom};
				else
					step = {{56{lane[7]}}, lane};
				len = $urandom_range(4, 24);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(4) == 0) begin
						send_item(REQ_VICTIM, set_i, 4'($urandom), pick_mask(), 8'($urandom),
							{$urandom, $urandom}, 1'($urandom), 4'($urandom));
						sent++;
					end
					if ($urandom_range(29) == 0)
						addr = {$urandom, $urandom};
					send_item(REQ_UPDATE, set_i, 4'($urandom), 16'($urandom),
						pc_base ^ 8'($urandom_range(3)), addr, $urandom_range(99) < 35,
						pick_nibble());
					addr = addr + step;
					sent++;
				end
			end else if (r < 85) begin
				if ($urandom_range(1))
					send_item(REQ_VICTIM, set_i, 4'($urandom), pick_mask(), pc_base,
						{$urandom, $urandom}, 1'($urandom), 4'($urandom));
				else
					send_item(REQ_UPDATE, set_i, 4'($urandom), 16'($urandom), pc_base,
						{$urandom, $urandom}, 1'($urandom), pick_nibble());
				sent++;
			end else begin
				send_item(req_kind_t'($urandom_range(1)), 11'($urandom), 4'($urandom),
					16'($urandom), 8'($urandom),
					($urandom_range(19) == 0) ? 64'd0 : {$urandom, $urandom},
					1'($urandom), 4'($urandom));
				sent++;
			end
		end
	endtask

	task automatic run_directed();
		int k;
		send_item(REQ_VICTIM, 11'd0, 4'd0, 16'h0000, 8'h00, 64'd0, 1'b0, 4'd0);
		send_item(REQ_VICTIM, 11'd2047, 4'd15, 16'h7FFF, 8'hFF, '1, 1'b1, 4'hF);
		send_item(REQ_VICTIM, 11'd5, 4'd0, 16'hFFFF, 8'h00, 64'd0, 1'b0, 4'd0);
		// zero address never starts a run
		send_item(REQ_UPDATE, 11'd0, 4'd0, 16'h0000, 8'h00, 64'd0, 1'b0, 4'd0);
		send_item(REQ_UPDATE, 11'd0, 4'd15, 16'hFFFF, 8'hFF, 64'd0, 1'b1, 4'hF);
		send_item(REQ_UPDATE, 11'd2047, 4'd15, 16'hFFFF, 8'hAA, '1, 1'b0, 4'd0);
		// negative stride run until the set streams, alternating bypass nibble
		for (k = 0; k < 10; k++)
			send_item(REQ_UPDATE, 11'd3, 4'(k), 16'h0000, 8'h5C, 64'h1000 - 64'(8 * k), 1'b0,
				(k % 2 == 0) ? 4'd0 : 4'd9);
		send_item(REQ_UPDATE, 11'd3, 4'd2, 16'h0000, 8'h5C, 64'h0FB0, 1'b1, 4'd1);
		send_item(REQ_VICTIM, 11'd3, 4'd0, 16'hFFFF, 8'h00, 64'd0, 1'b0, 4'd0);
		send_item(REQ_VICTIM, 11'd3, 4'd0, 16'hFFFF, 8'h00, 64'd0, 1'b0, 4'd0);
		send_item(REQ_UPDATE, 11'd2047, 4'd7, 16'h0000, 8'hFF, '1, 1'b1, 4'd3);
		send_item(REQ_UPDATE, 11'd2047, 4'd8, 16'h0000, 8'hFF, 64'd1, 1'b0, 4'd3);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		calm      = 1'b1;
		hold_req  = 1'b0;
		hot_sets[0] = 11'd0;
		hot_sets[1] = 11'd2047;
		for (int i = 2; i < 12; i++)
			hot_sets[i] = 11'($urandom);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_regs(4'd6, 2'd2, 2'd1);
		write_reg(CFG_SPARE, 4'($urandom));
		calm = 1'b0;
		run_directed();

		settle();
		set_regs(4'd0, 2'd0, 2'd0);
		calm = 1'b1;
		run_random(200);
		calm = 1'b0;
		run_random(100);

		settle();
		set_regs(4'd15, 2'd3, 2'd3);
		hold_req = 1'b1;
		run_random(300);

		settle();
		set_regs(4'($urandom_range(1, 14)), 2'($urandom), 2'($urandom));
		run_random(300);

		settle();
		set_regs(4'd3, 2'd1, 2'd2);
		run_random(330);

		settle();
		repeat (8) @(posedge clk);
		if (err_total == 0)
			$display("ship_srrip_stream_replacement_tb: done, clean");
		else
			$display("ship_srrip_stream_replacement_tb: done, errors");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int unsigned held;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_req = 1'b0;
			end
			m_tready = calm || ($urandom_range(99) >= 7);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("ship_srrip_stream_replacement_tb: done, errors");
		$finish;
	end

endmodule
